[src/ttms_pkg.sv]
`default_nettype none

package ttms_pkg;

  localparam int unsigned NOW_W    = 64;
  localparam int unsigned DUR_MS_W = 23;
  localparam int unsigned US_PER_MS = 1000;
  // 23-bit ms value times 1000 fits in 33 bits
  localparam int unsigned DUR_US_W = 33;
  localparam int unsigned DEF_TIME_WIDTH = 64;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAB    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_GRAB    = 3'd1,
    PH_TIE     = 3'd2,
    PH_CUT     = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef struct packed {
    logic [NOW_W-1:0] now_us;
    logic             start_request;
  } upd_word_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       grabber_forward;
    logic       grabber_reverse;
    logic       tier_forward;
    logic       tier_reverse;
    logic       start_taken;
  } res_word_t;

endpackage

`default_nettype wire

[src/timed_tying_motor_sequencer_unit.sv]
`default_nettype none
// Channel  Direction  Handshake                Word
// upd      in         upd_valid / upd_stall    upd_word_t: now_us, start_request
// res      out        res_valid / res_stall    res_word_t: phase, motor lines, start_taken
// cfg      in         cfg_valid / cfg_ready    cfg_index (register), cfg_data (ms)
//
// One update word per clock, sustained while res_stall stays low; a result word is
// valid once its update has passed the input register, then the result register.
// Phase state advances when the input register hands its word to the result
// register, so the elapsed check is one subtract and one compare per cycle.
// A stalled result holds; the input register then fills and upd_stall rises.
// rst is synchronous: phase idle, no pending start, durations zero, both
// registers empty. Duration writes are taken in every cycle (cfg_ready high).

module timed_tying_motor_sequencer_unit
  import ttms_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = DEF_TIME_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 upd_valid,
  output logic                      upd_stall,
  input  wire upd_word_t            upd_word,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output res_word_t                 res_word,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DUR_MS_W-1:0]  cfg_data
);

  // compare width covers both elapsed time and scaled duration
  localparam int unsigned CMP_W = (TIME_WIDTH > DUR_US_W) ? TIME_WIDTH : DUR_US_W;

  // durations, kept pre-scaled to microseconds
  logic [DUR_US_W-1:0] grab_us;
  logic [DUR_US_W-1:0] tie_us;
  logic [DUR_US_W-1:0] cut_us;
  logic [DUR_US_W-1:0] release_us;
  logic [DUR_US_W-1:0] cfg_us;

  // input register
  logic      s1_valid;
  upd_word_t s1_word;
  logic      adv;

  // sequencer state
  phase_t                phase;
  phase_t                phase_next;
  logic [TIME_WIDTH-1:0] stamp;
  logic                  pending;
  logic                  pending_next;

  // per-update datapath
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] diff;
  logic [DUR_US_W-1:0]   dur_sel;
  logic                  done;
  logic                  pend_eff;
  logic                  taken;
  logic                  restamp;
  res_word_t             res_calc;

  assign cfg_ready = 1'b1;
  assign cfg_us    = DUR_US_W'(cfg_data) * DUR_US_W'(US_PER_MS);

  always_ff @(posedge clk) begin
    if (rst) begin
      grab_us    <= '0;
      tie_us     <= '0;
      cut_us     <= '0;
      release_us <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRAB:    grab_us    <= cfg_us;
        REG_TIE:     tie_us     <= cfg_us;
        REG_CUT:     cut_us     <= cfg_us;
        REG_RELEASE: release_us <= cfg_us;
        default:     ;
      endcase
    end
  end

  // word moves to the result register when that one is free or draining
  assign adv       = s1_valid && (!res_valid || !res_stall);
  assign upd_stall = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (upd_valid && !upd_stall) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_valid && !upd_stall) begin
      s1_word <= upd_word;
    end
  end

  assign now_t = s1_word.now_us[TIME_WIDTH-1:0];
  assign diff  = now_t - stamp;

  always_comb begin
    case (phase)
      PH_GRAB:    dur_sel = grab_us;
      PH_TIE:     dur_sel = tie_us;
      PH_CUT:     dur_sel = cut_us;
      PH_RELEASE: dur_sel = release_us;
      default:    dur_sel = '0;
    endcase
  end

  assign done     = CMP_W'(diff) > CMP_W'(dur_sel);
  assign pend_eff = pending || s1_word.start_request;

  // next phase, pending start and result word
  always_comb begin
    phase_next   = phase;
    pending_next = pend_eff;
    taken        = 1'b0;
    restamp      = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (pend_eff) begin
          phase_next   = PH_GRAB;
          pending_next = 1'b0;
          taken        = 1'b1;
          restamp      = 1'b1;
        end
      end
      PH_GRAB: begin
        if (done) begin
          phase_next = PH_TIE;
          restamp    = 1'b1;
        end
      end
      PH_TIE: begin
        if (done) begin
          phase_next = PH_CUT;
          restamp    = 1'b1;
        end
      end
      PH_CUT: begin
        if (done) begin
          phase_next = PH_RELEASE;
          restamp    = 1'b1;
        end
      end
      PH_RELEASE: begin
        // back to idle keeps the old stamp
        if (done) begin
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase

    res_calc                 = '0;
    res_calc.phase           = phase_next;
    res_calc.grabber_forward = (phase_next == PH_GRAB);
    res_calc.tier_forward    = (phase_next == PH_TIE);
    res_calc.tier_reverse    = (phase_next == PH_CUT);
    res_calc.grabber_reverse = (phase_next == PH_RELEASE);
    res_calc.start_taken     = taken;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      pending <= 1'b0;
      stamp   <= '0;
    end else if (adv) begin
      phase   <= phase_next;
      pending <= pending_next;
      if (restamp) begin
        stamp <= now_t;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_word <= res_calc;
    end
  end

`ifndef SYNTH
  a_taken_enters_grab: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.start_taken |-> res_word.phase == PH_GRAB)
    else $error("start taken without entering grab");

  a_one_motor_line: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot0({res_word.grabber_forward, res_word.grabber_reverse,
                            res_word.tier_forward, res_word.tier_reverse}))
    else $error("more than one motor line driven");

  a_phase_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(phase))
    else $error("phase changed without an update");

  a_taken_from_idle: assert property (@(posedge clk) disable iff (rst)
    adv && taken |-> phase == PH_IDLE && pend_eff)
    else $error("start taken outside idle");
`endif

endmodule

`default_nettype wire

[test/tb_timed_tying_motor_sequencer_unit.sv]
`default_nettype none

// Five-phase tying sequencer bench: a directed table, then random episodes
// of advancing time. Each episode programs the durations, then streams updates.
module tb_timed_tying_motor_sequencer_unit;
  import ttms_pkg::*;

  localparam int unsigned TW = DEF_TIME_WIDTH;
  localparam logic [63:0] TMASK = {64{1'b1}} >> (64 - TW);
  localparam logic [DUR_MS_W-1:0] MS_MAX = {DUR_MS_W{1'b1}};
  localparam logic [DUR_MS_W-1:0] MS_TOP = 23'd4294967; // top of the spec range
  localparam int unsigned EPISODES = 12;
  localparam int unsigned EP_WORDS = 96;
  localparam int unsigned CYCLE_LIMIT = 500000;

  // motor line bits as {tr, tf, gr, gf}
  localparam logic [3:0] M_OFF = 4'b0000;
  localparam logic [3:0] M_GF  = 4'b0001;
  localparam logic [3:0] M_GR  = 4'b0010;
  localparam logic [3:0] M_TF  = 4'b0100;
  localparam logic [3:0] M_TR  = 4'b1000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 upd_valid = 1'b0;
  logic                 upd_stall;
  upd_word_t            upd_word = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  res_word_t            res_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GRAB;
  logic [DUR_MS_W-1:0]  cfg_data = '0;

  timed_tying_motor_sequencer_unit #(.TIME_WIDTH(TW)) dut (
    .clk       (clk),
    .rst       (rst),
    .upd_valid (upd_valid),
    .upd_stall (upd_stall),
    .upd_word  (upd_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequencer mirror: phase, entry stamp, latched start, motor lines, durations.
  // ---------------------------------------------------------------------------
  phase_t              seq_phase = PH_IDLE;
  logic [63:0]         seq_entry = '0;
  logic                seq_pending = 1'b0;
  logic [3:0]          seq_motors = M_OFF;
  logic [DUR_MS_W-1:0] dur_ms [4] = '{default: '0};

  res_word_t   due_words[$];  // result words still owed by the block
  int unsigned bad = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;   // episode with no idling on either side

  function automatic res_word_t pack_result(phase_t p, logic [3:0] m, logic taken);
    res_word_t r;
    r.phase           = p;
    r.grabber_forward = m[0];
    r.grabber_reverse = m[1];
    r.tier_forward    = m[2];
    r.tier_reverse    = m[3];
    r.start_taken     = taken;
    return r;
  endfunction

  // strictly greater: a phase needs more than ms*1000 us on the (wrapped) clock
  function automatic bit overdue(logic [63:0] t, logic [DUR_MS_W-1:0] ms);
    return ((t - seq_entry) & TMASK) > (64'(ms) * 64'd1000);
  endfunction

  function automatic void enter_phase(phase_t p, logic [3:0] m, logic [63:0] t);
    seq_phase  = p;
    seq_motors = m;
    seq_entry  = t;
  endfunction

  function automatic res_word_t step_sequencer(upd_word_t w);
    logic [63:0] t;
    logic        taken;
    t     = w.now_us & TMASK;
    taken = 1'b0;
    if (w.start_request) seq_pending = 1'b1;
    case (seq_phase)
      PH_IDLE: if (seq_pending) begin
        seq_pending = 1'b0;
        taken       = 1'b1;
        enter_phase(PH_GRAB, M_GF, t);
      end
      PH_GRAB:    if (overdue(t, dur_ms[REG_GRAB])) enter_phase(PH_TIE, M_TF, t);
      PH_TIE:     if (overdue(t, dur_ms[REG_TIE])) enter_phase(PH_CUT, M_TR, t);
      PH_CUT:     if (overdue(t, dur_ms[REG_CUT])) enter_phase(PH_RELEASE, M_GR, t);
      // release ends into idle without a new stamp; a pending start waits a word
      PH_RELEASE: if (overdue(t, dur_ms[REG_RELEASE])) begin
        seq_phase  = PH_IDLE;
        seq_motors = M_OFF;
      end
      default: begin
        seq_phase  = PH_IDLE;
        seq_motors = M_OFF;
      end
    endcase
    return pack_result(seq_phase, seq_motors, taken);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving side. All NBAs land on a rising edge; each task returns on an edge.
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (calm || p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // typed = 1: the row carries its own expected word instead of the mirror's
  task automatic send_update(input upd_word_t w, input bit typed, input res_word_t want);
    res_word_t guess;
    int unsigned gap;
    gap = pick_gap();
    cfg_valid <= 1'b0;
    upd_valid <= 1'b1;
    upd_word  <= w;
    do @(posedge clk); while (upd_stall);
    guess = step_sequencer(w);
    due_words.push_back(typed ? want : guess);
    if (gap != 0) begin
      upd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every owed word has come back
  task automatic hold_until_drained();
    upd_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
  endtask

  // cfg_valid stays high for back-to-back writes; the next update lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_MS_W-1:0] ms);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= ms;
    do @(posedge clk); while (!cfg_ready);
    dur_ms[idx] = ms;
  endtask

  function automatic logic [DUR_MS_W-1:0] pick_ms();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return MS_MAX;
      2:       return MS_TOP;
      default: return DUR_MS_W'($urandom_range(0, 3));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table: one row is an update (mirror-checked or typed) or a write.
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {ROW_UPD, ROW_UPD_TYPED, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    upd_word_t           w;
    res_word_t           want;
    logic [CFG_IDX_W-1:0] idx;
    logic [DUR_MS_W-1:0]  ms;
  } row_t;

  row_t plan[$];

  function automatic row_t upd_row(logic [63:0] t, logic st);
    row_t r;
    r.kind = ROW_UPD;
    r.w.now_us = t;
    r.w.start_request = st;
    r.want = '0;
    r.idx = REG_GRAB;
    r.ms = '0;
    return r;
  endfunction

  function automatic row_t typed_row(logic [63:0] t, logic st, res_word_t want);
    row_t r;
    r = upd_row(t, st);
    r.kind = ROW_UPD_TYPED;
    r.want = want;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [DUR_MS_W-1:0] ms);
    row_t r;
    r = upd_row('0, 1'b0);
    r.kind = ROW_CFG;
    r.idx = idx;
    r.ms = ms;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall runs, and the in-order compare.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk) begin : drive_res_stall
    int unsigned p;
    if (stall_left != 0) begin
      stall_left--;
    end else begin
      p = $urandom_range(0, 99);
      if (calm || p < 50) begin
        res_stall <= 1'b0;
        stall_left = $urandom_range(1, 8);
      end else if (p < 90) begin
        res_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        res_stall <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      bad++;
    end
  endtask

  always @(posedge clk) begin : check_results
    res_word_t w;
    if (!rst && res_valid && !res_stall) begin
      if (due_words.size() == 0) begin
        $display("%0t: result word %h with nothing owed", $time, res_word);
        bad++;
      end else begin
        w = due_words.pop_front();
        check_field("phase", w.phase, res_word.phase);
        check_field("grabber_forward", w.grabber_forward, res_word.grabber_forward);
        check_field("grabber_reverse", w.grabber_reverse, res_word.grabber_reverse);
        check_field("tier_forward", w.tier_forward, res_word.tier_forward);
        check_field("tier_reverse", w.tier_reverse, res_word.tier_reverse);
        check_field("start_taken", w.start_taken, res_word.start_taken);
      end
    end
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned ep;
    int unsigned k;
    int unsigned r;
    logic [63:0] us_now;
    upd_word_t   w;

    // all durations zero: every timed phase ends on the first time change
    plan.push_back(typed_row(64'd0, 1'b0, pack_result(PH_IDLE, M_OFF, 1'b0)));
    plan.push_back(typed_row(64'd0, 1'b1, pack_result(PH_GRAB, M_GF, 1'b1)));
    plan.push_back(upd_row(64'd0, 1'b1));   // request while busy, same time: no move
    plan.push_back(upd_row(64'd1, 1'b0));   // grab -> tie
    plan.push_back(upd_row(64'd1, 1'b0));
    plan.push_back(upd_row(64'd2, 1'b0));   // tie -> cut
    plan.push_back(upd_row(64'd3, 1'b0));   // cut -> release
    plan.push_back(upd_row(64'd4, 1'b0));   // release -> idle, pending start not yet taken
    plan.push_back(typed_row(64'd4, 1'b0, pack_result(PH_GRAB, M_GF, 1'b1)));
    plan.push_back(upd_row(64'd5, 1'b0));
    plan.push_back(upd_row(64'd6, 1'b0));
    plan.push_back(upd_row(64'd7, 1'b0));
    plan.push_back(upd_row(64'd8, 1'b0));
    // widest durations, plus a one-ms cut and a zero-length release
    plan.push_back(cfg_row(REG_GRAB, MS_MAX));
    plan.push_back(cfg_row(REG_TIE, MS_TOP));
    plan.push_back(cfg_row(REG_CUT, 23'd1));
    plan.push_back(cfg_row(REG_RELEASE, 23'd0));
    // grab entered just below the wrap point; boundary is exactly max ms
    plan.push_back(upd_row(64'hFFFF_FFFF_FFFF_FFF0, 1'b1));
    plan.push_back(typed_row(64'd8388606984, 1'b0, pack_result(PH_GRAB, M_GF, 1'b0)));
    plan.push_back(typed_row(64'd8388606985, 1'b0, pack_result(PH_TIE, M_TF, 1'b0)));
    plan.push_back(upd_row(64'd12683573985, 1'b0));   // exactly the tie length: hold
    plan.push_back(upd_row(64'd12683573986, 1'b0));   // tie -> cut
    plan.push_back(upd_row(64'd12683574986, 1'b0));   // exactly 1000 us: hold
    plan.push_back(upd_row(64'd12683574987, 1'b0));   // cut -> release
    plan.push_back(upd_row(64'd12683574987, 1'b0));   // zero length, same time: hold
    // time stepping back wraps to a huge elapsed value
    plan.push_back(typed_row(64'd12683574986, 1'b0, pack_result(PH_IDLE, M_OFF, 1'b0)));
    plan.push_back(typed_row({64{1'b1}}, 1'b0, pack_result(PH_IDLE, M_OFF, 1'b0)));
    plan.push_back(upd_row({64{1'b1}}, 1'b1));
    plan.push_back(upd_row(64'd0, 1'b0));             // one us after wrap: still grab

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        hold_until_drained();
        write_reg(plan[i].idx, plan[i].ms);
      end else begin
        send_update(plan[i].w, plan[i].kind == ROW_UPD_TYPED, plan[i].want);
      end
    end

    // Random episodes. Each drains the pipe, reprograms all four durations,
    // then streams mostly advancing time with the odd jump, wrap or step back.
    us_now = 64'd0;
    for (ep = 0; ep < EPISODES; ep++) begin
      hold_until_drained();
      calm = (ep % 4 == 3);
      for (r = 0; r < 4; r++) begin
        if (ep == 0) write_reg(CFG_IDX_W'(r), '0);
        else if (ep == 1) write_reg(CFG_IDX_W'(r), MS_MAX);
        else write_reg(CFG_IDX_W'(r), pick_ms());
      end
      for (k = 0; k < EP_WORDS; k++) begin
        case ($urandom_range(0, 19))
          0:       us_now = {$urandom, $urandom};
          1:       us_now = {64{1'b1}} - 64'($urandom_range(0, 4000));
          2:       us_now = us_now - 64'($urandom_range(1, 50));
          3, 4, 5: ;  // same time as the last word
          default: us_now = us_now + 64'($urandom_range(1, 1800));
        endcase
        w.now_us = us_now;
        w.start_request = ($urandom_range(0, 9) < 3);
        send_update(w, 1'b0, '0);
      end
    end
    calm = 1'b0;

    hold_until_drained();
    repeat (10) @(posedge clk);
    if (bad == 0 && due_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
src/ttms_pkg.sv
src/timed_tying_motor_sequencer_unit.sv
test/tb_timed_tying_motor_sequencer_unit.sv
